// ===== src/vcsw_pkg.sv =====
package vcsw_pkg;

  // Return stack sizing.
  localparam int unsigned RETURN_STACK_DEPTH = 8;
  localparam int unsigned DEPTH_W = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int unsigned SLOT_W = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(RETURN_STACK_DEPTH);

  // Queue between the parser and the write sequencer.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input operations.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Command bytes.
  localparam logic [7:0] CMD_JUMP   = 8'h4C;
  localparam logic [7:0] CMD_RETURN = 8'h60;

  // Record fields and address map.
  localparam logic [6:0] FULL_LEN     = 7'd64;
  localparam logic [5:0] PALETTE_PAGE = 6'h3F;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OPCODE = 3'd1,
    PH_JLO    = 3'd2,
    PH_JHI    = 3'd3,
    PH_DLO    = 3'd4,
    PH_FLAGS  = 3'd5,
    PH_DATA   = 3'd6
  } phase_e;

  // One parsed byte's work for the write sequencer.
  typedef struct packed {
    logic [6:0]  count;
    logic [13:0] vram_addr;
    logic        stride_32;
    logic [7:0]  data;
    logic        fetch_req;
    logic [15:0] fetch_addr;
    logic        done;
    logic        stack_err;
  } job_t;

endpackage

// ===== src/vcsw_queue.sv =====
module vcsw_queue
  import vcsw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/vcsw_front.sv =====
module vcsw_front
  import vcsw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] start_address_i,
  input  logic [7:0]  fetched_byte_i,
  input  logic        queue_full_i,
  output logic        job_push_o,
  output job_t        job_o
);

  phase_e             phase_q, phase_d;
  logic [15:0]        src_ptr_q, src_ptr_d;
  logic [13:0]        vid_ptr_q, vid_ptr_d;
  logic [6:0]         remain_q, remain_d;
  logic               stride_q, stride_d;
  logic               fill_q, fill_d;
  logic [7:0]         held_q, held_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [15:0]        stack_q [RETURN_STACK_DEPTH];

  logic               push_ret;
  logic [DEPTH_W-1:0] depth_m1;
  logic [15:0]        src_inc;
  logic [6:0]         wr_count;
  logic [13:0]        vid_adv;
  logic               done, err;
  logic [7:0]         b;

  assign in_ready_o = !queue_full_i;
  assign job_push_o = in_valid_i && in_ready_o;
  assign b          = fetched_byte_i;
  assign depth_m1   = depth_q - 1'b1;
  assign src_inc    = src_ptr_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    src_ptr_d = src_ptr_q;
    vid_ptr_d = vid_ptr_q;
    remain_d  = remain_q;
    stride_d  = stride_q;
    fill_d    = fill_q;
    held_d    = held_q;
    depth_d   = depth_q;
    push_ret  = 1'b0;
    wr_count  = '0;
    done      = 1'b0;
    err       = 1'b0;
    if (operation_i == OP_START) begin
      src_ptr_d = start_address_i;
      phase_d   = PH_OPCODE;
      depth_d   = '0;
      remain_d  = '0;
    end else begin
      unique case (phase_q)
        PH_OPCODE: begin
          src_ptr_d = src_inc;
          if (b[7]) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else if (b == CMD_JUMP) begin
            phase_d = PH_JLO;
          end else if (b == CMD_RETURN) begin
            if (depth_q == '0) begin
              err     = 1'b1;
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              depth_d   = depth_m1;
              src_ptr_d = stack_q[depth_m1[SLOT_W-1:0]];
            end
          end else begin
            held_d  = b;
            phase_d = PH_DLO;
          end
        end
        PH_JLO: begin
          src_ptr_d = src_inc;
          held_d    = b;
          phase_d   = PH_JHI;
        end
        PH_JHI: begin
          src_ptr_d = src_inc;
          if (depth_q >= DEPTH_FULL) begin
            err     = 1'b1;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            push_ret  = 1'b1;
            depth_d   = depth_q + 1'b1;
            src_ptr_d = {b, held_q};
            phase_d   = PH_OPCODE;
          end
        end
        PH_DLO: begin
          src_ptr_d = src_inc;
          vid_ptr_d = {held_q[5:0], b};
          phase_d   = PH_FLAGS;
        end
        PH_FLAGS: begin
          src_ptr_d = src_inc;
          remain_d  = (b[5:0] == '0) ? FULL_LEN : {1'b0, b[5:0]};
          stride_d  = b[7];
          fill_d    = b[6];
          phase_d   = PH_DATA;
        end
        PH_DATA: begin
          src_ptr_d = src_inc;
          held_d    = b;
          // A fill record writes its whole run from this one byte.
          if (fill_q) begin
            wr_count = remain_q;
          end else begin
            wr_count = {6'd0, (remain_q != '0)};
          end
          remain_d = remain_q - wr_count;
          if (remain_d == '0) begin
            phase_d = PH_OPCODE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // The video pointer moves past every write of this transaction.
  assign vid_adv = stride_q ? {2'b00, wr_count, 5'b00000} : {7'd0, wr_count};

  always_comb begin
    job_o.count      = wr_count;
    job_o.vram_addr  = vid_ptr_q;
    job_o.stride_32  = stride_q;
    job_o.data       = b;
    job_o.fetch_req  = (phase_d != PH_IDLE);
    job_o.fetch_addr = src_ptr_d;
    job_o.done       = done;
    job_o.stack_err  = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      src_ptr_q <= '0;
      vid_ptr_q <= '0;
      remain_q  <= '0;
      stride_q  <= 1'b0;
      fill_q    <= 1'b0;
      held_q    <= '0;
      depth_q   <= '0;
    end else if (job_push_o) begin
      phase_q   <= phase_d;
      src_ptr_q <= src_ptr_d;
      vid_ptr_q <= (phase_q == PH_DATA && operation_i == OP_BYTE) ? vid_ptr_q + vid_adv
                                                                  : vid_ptr_d;
      remain_q  <= remain_d;
      stride_q  <= stride_d;
      fill_q    <= fill_d;
      held_q    <= held_d;
      depth_q   <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_push_o && push_ret) begin
      stack_q[depth_q[SLOT_W-1:0]] <= src_inc;
    end
  end

endmodule

// ===== src/vcsw_back.sv =====
module vcsw_back
  import vcsw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fetch_request_o,
  output logic [15:0] fetch_address_o,
  output logic        vram_write_o,
  output logic [13:0] vram_address_o,
  output logic [7:0]  vram_data_o,
  output logic        to_palette_o,
  output logic [4:0]  palette_index_o,
  output logic        done_res_o,
  output logic        stack_error_o,
  output logic        last_o
);

  logic        busy_q, busy_d;
  job_t        job_q;
  logic [6:0]  rem_q;
  logic [13:0] vp_q;
  logic        out_valid_q, out_valid_d;

  logic        advance, emit, is_wr, is_last, pal;

  logic        fetch_request_q, vram_write_q, to_palette_q, done_res_q, stack_error_q;
  logic        last_q;
  logic [15:0] fetch_address_q;
  logic [13:0] vram_address_q;
  logic [7:0]  vram_data_q;
  logic [4:0]  palette_index_q;

  assign advance   = !out_valid_q || out_ready_i;
  assign emit      = busy_q && advance;
  assign job_pop_o = !busy_q && job_valid_i;
  assign is_wr     = (rem_q != '0);
  // A job without writes still gives one status transaction.
  assign is_last   = (rem_q[6:1] == '0);
  assign pal       = (vp_q[13:8] == PALETTE_PAGE);

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (job_pop_o) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      rem_q <= job_i.count;
      vp_q  <= job_i.vram_addr;
    end else if (emit) begin
      rem_q <= is_wr ? rem_q - 1'b1 : rem_q;
      vp_q  <= vp_q + (job_q.stride_32 ? 14'd32 : 14'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      vram_write_q    <= is_wr;
      vram_address_q  <= is_wr ? vp_q : '0;
      vram_data_q     <= is_wr ? job_q.data : '0;
      to_palette_q    <= is_wr && pal;
      palette_index_q <= (is_wr && pal) ? vp_q[4:0] : '0;
      last_q          <= is_last;
      fetch_request_q <= is_last && job_q.fetch_req;
      fetch_address_q <= is_last ? job_q.fetch_addr : '0;
      done_res_q      <= is_last && job_q.done;
      stack_error_q   <= is_last && job_q.stack_err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fetch_request_o = fetch_request_q;
  assign fetch_address_o = fetch_address_q;
  assign vram_write_o    = vram_write_q;
  assign vram_address_o  = vram_address_q;
  assign vram_data_o     = vram_data_q;
  assign to_palette_o    = to_palette_q;
  assign palette_index_o = palette_index_q;
  assign done_res_o      = done_res_q;
  assign stack_error_o   = stack_error_q;
  assign last_o          = last_q;

endmodule

// ===== src/vram_command_string_writer.sv =====
// Path: an accepted byte's job is queued, then loaded into the sequencer's job
// register; results are registered at the outputs, held while out_ready_i is low.
// Each byte gives one result and a fill record len; the next byte loads after the last.
// A two-entry queue lets the parser keep accepting bytes while a fill burst drains.
// Reset: rst_ni clears the parser to idle, empties the queue and drops out_valid_o;
// the return stack contents are not cleared.
module vram_command_string_writer
  import vcsw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] start_address_i,
  input  logic [7:0]  fetched_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fetch_request_o,
  output logic [15:0] fetch_address_o,
  output logic        vram_write_o,
  output logic [13:0] vram_address_o,
  output logic [7:0]  vram_data_o,
  output logic        to_palette_o,
  output logic [4:0]  palette_index_o,
  output logic        done_res_o,
  output logic        stack_error_o,
  output logic        last_o
);

  job_t push_job, pop_job;
  logic push, queue_full, queue_valid, pop;

  vcsw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .start_address_i(start_address_i),
    .fetched_byte_i (fetched_byte_i),
    .queue_full_i   (queue_full),
    .job_push_o     (push),
    .job_o          (push_job)
  );

  vcsw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .pop_data_o (pop_job)
  );

  vcsw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (queue_valid),
    .job_i          (pop_job),
    .job_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fetch_request_o(fetch_request_o),
    .fetch_address_o(fetch_address_o),
    .vram_write_o   (vram_write_o),
    .vram_address_o (vram_address_o),
    .vram_data_o    (vram_data_o),
    .to_palette_o   (to_palette_o),
    .palette_index_o(palette_index_o),
    .done_res_o     (done_res_o),
    .stack_error_o  (stack_error_o),
    .last_o         (last_o)
  );

endmodule

// ===== dv/vram_command_string_writer_test.sv =====
`timescale 1ns / 100ps

module vram_command_string_writer_test;
  import vcsw_pkg::*;

  localparam int RANDOM_ITEMS = 180;
  localparam int TABLE_ROWS = 26;

  typedef struct packed {
    logic        fetch_req;
    logic [15:0] fetch_addr;
    logic        wr;
    logic [13:0] vaddr;
    logic [7:0]  vdata;
    logic        pal;
    logic [4:0]  pidx;
    logic        done;
    logic        err;
    logic        last;
  } vram_result_t;

  // One directed row. Where typed is set, the row gives a single status-only
  // result whose status fields are written out here.
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        typed;
    logic        fetch_req;
    logic [15:0] fetch_addr;
    logic        done;
    logic        err;
  } walk_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = OP_BYTE;
  logic [15:0] start_address_i = '0;
  logic [7:0]  fetched_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        fetch_request_o;
  logic [15:0] fetch_address_o;
  logic        vram_write_o;
  logic [13:0] vram_address_o;
  logic [7:0]  vram_data_o;
  logic        to_palette_o;
  logic [4:0]  palette_index_o;
  logic        done_res_o;
  logic        stack_error_o;
  logic        last_o;

  // Mirror of the parser state.
  phase_e      parse_state = PH_IDLE;
  logic [15:0] src_ptr = '0;
  logic [13:0] vid_ptr = '0;
  logic [6:0]  remaining = '0;
  logic        stride32 = 1'b0;
  logic        fill_mode = 1'b0;
  logic [7:0]  held = '0;
  logic [15:0] ret_stack [RETURN_STACK_DEPTH];
  int          ret_depth = 0;

  vram_result_t awaited_results [$];
  walk_row_t    walk_table [TABLE_ROWS];

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int          mismatch_count = 0;
  int          stim_count = 0;
  int          results_checked = 0;
  int          writes_seen = 0;
  int          stops_seen = 0;
  int          stack_errors_seen = 0;

  vram_command_string_writer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .start_address_i (start_address_i),
    .fetched_byte_i  (fetched_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fetch_request_o (fetch_request_o),
    .fetch_address_o (fetch_address_o),
    .vram_write_o    (vram_write_o),
    .vram_address_o  (vram_address_o),
    .vram_data_o     (vram_data_o),
    .to_palette_o    (to_palette_o),
    .palette_index_o (palette_index_o),
    .done_res_o      (done_res_o),
    .stack_error_o   (stack_error_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  // Works out the results of one accepted transaction and queues them.
  task automatic predict_command_byte(input logic op, input logic [15:0] addr,
                                      input logic [7:0] b);
    vram_result_t burst [64];
    int n;
    int count;
    logic stop;
    logic bad;
    n = 0;
    stop = 1'b0;
    bad = 1'b0;
    if (op == OP_START) begin
      src_ptr = addr;
      parse_state = PH_OPCODE;
      ret_depth = 0;
      remaining = '0;
    end else begin
      case (parse_state)
        PH_OPCODE: begin
          src_ptr++;
          if (b[7]) begin
            parse_state = PH_IDLE;
            stop = 1'b1;
          end else if (b == CMD_JUMP) begin
            parse_state = PH_JLO;
          end else if (b == CMD_RETURN) begin
            if (ret_depth == 0) begin
              bad = 1'b1;
              stop = 1'b1;
              parse_state = PH_IDLE;
            end else begin
              ret_depth--;
              src_ptr = ret_stack[ret_depth];
            end
          end else begin
            held = b;
            parse_state = PH_DLO;
          end
        end
        PH_JLO: begin
          src_ptr++;
          held = b;
          parse_state = PH_JHI;
        end
        PH_JHI: begin
          src_ptr++;
          if (ret_depth >= RETURN_STACK_DEPTH) begin
            bad = 1'b1;
            stop = 1'b1;
            parse_state = PH_IDLE;
          end else begin
            ret_stack[ret_depth] = src_ptr;
            ret_depth++;
            src_ptr = {b, held};
            parse_state = PH_OPCODE;
          end
        end
        PH_DLO: begin
          src_ptr++;
          vid_ptr = {held[5:0], b};
          parse_state = PH_FLAGS;
        end
        PH_FLAGS: begin
          src_ptr++;
          remaining = (b[5:0] == 6'd0) ? FULL_LEN : {1'b0, b[5:0]};
          stride32 = b[7];
          fill_mode = b[6];
          parse_state = PH_DATA;
        end
        PH_DATA: begin
          src_ptr++;
          held = b;
          if (fill_mode) count = remaining;
          else count = (remaining != 0) ? 1 : 0;
          for (int i = 0; i < count; i++) begin
            burst[n] = '0;
            burst[n].wr = 1'b1;
            burst[n].vaddr = vid_ptr;
            burst[n].vdata = b;
            burst[n].pal = (vid_ptr[13:8] == PALETTE_PAGE);
            burst[n].pidx = burst[n].pal ? vid_ptr[4:0] : 5'd0;
            n++;
            vid_ptr = vid_ptr + (stride32 ? 14'd32 : 14'd1);
            remaining--;
          end
          if (remaining == 0) parse_state = PH_OPCODE;
        end
        default: parse_state = PH_IDLE;
      endcase
    end
    if (n == 0) begin
      burst[0] = '0;
      n = 1;
    end
    // Status travels on the final result of the transaction only.
    burst[n-1].fetch_req = (parse_state != PH_IDLE);
    burst[n-1].fetch_addr = src_ptr;
    burst[n-1].done = stop;
    burst[n-1].err = bad;
    burst[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_results.push_back(burst[i]);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic drive_item(input logic op, input logic [15:0] addr, input logic [7:0] b,
                            input logic typed, input vram_result_t typed_res);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    start_address_i = addr;
    fetched_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_START || parse_state != PH_IDLE) stim_count++;
    predict_command_byte(op, addr, b);
    if (typed) begin
      void'(awaited_results.pop_back());
      awaited_results.push_back(typed_res);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    vram_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, expected none, actual addr 0x%0h data 0x%0h",
                 $time, vram_address_o, vram_data_o);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (vram_write_o) writes_seen++;
        if (done_res_o) stops_seen++;
        if (stack_error_o) stack_errors_seen++;
        compare_field("fetch_request", want.fetch_req, fetch_request_o);
        compare_field("fetch_address", want.fetch_addr, fetch_address_o);
        compare_field("vram_write", want.wr, vram_write_o);
        compare_field("vram_address", want.vaddr, vram_address_o);
        compare_field("vram_data", want.vdata, vram_data_o);
        compare_field("to_palette", want.pal, to_palette_o);
        compare_field("palette_index", want.pidx, palette_index_o);
        compare_field("done_res", want.done, done_res_o);
        compare_field("stack_error", want.err, stack_error_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  initial begin
    vram_result_t typed_res;
    logic         op;
    logic [15:0]  addr;
    logic [7:0]   b;
    int           pick;
    int           base;
    logic         nest_mode;
    logic         first_program;

    nest_mode = 1'b0;
    first_program = 1'b1;

    // Byte while idle, start at the top of memory, end byte with pointer wrap.
    walk_table[0]  = '{OP_BYTE,  16'h0000, 8'h12, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[1]  = '{OP_START, 16'hFFFF, 8'h00, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0};
    walk_table[2]  = '{OP_BYTE,  16'h0000, 8'hFF, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0};
    // Return with an empty stack.
    walk_table[3]  = '{OP_START, 16'h1234, 8'h00, 1'b1, 1'b1, 16'h1234, 1'b0, 1'b0};
    walk_table[4]  = '{OP_BYTE,  16'h0000, 8'h60, 1'b1, 1'b0, 16'h1235, 1'b1, 1'b1};
    // Jump, then a fill that starts in the palette and wraps the video pointer.
    walk_table[5]  = '{OP_START, 16'h8000, 8'h00, 1'b1, 1'b1, 16'h8000, 1'b0, 1'b0};
    walk_table[6]  = '{OP_BYTE,  16'h0000, 8'h4C, 1'b1, 1'b1, 16'h8001, 1'b0, 1'b0};
    walk_table[7]  = '{OP_BYTE,  16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[8]  = '{OP_BYTE,  16'h0000, 8'hC0, 1'b1, 1'b1, 16'hC000, 1'b0, 1'b0};
    walk_table[9]  = '{OP_BYTE,  16'h0000, 8'h3F, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[10] = '{OP_BYTE,  16'h0000, 8'hFE, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[11] = '{OP_BYTE,  16'h0000, 8'h44, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[12] = '{OP_BYTE,  16'h0000, 8'hA5, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    // Copy of two bytes with stride 32.
    walk_table[13] = '{OP_BYTE,  16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[14] = '{OP_BYTE,  16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[15] = '{OP_BYTE,  16'h0000, 8'h82, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[16] = '{OP_BYTE,  16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[17] = '{OP_BYTE,  16'h0000, 8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[18] = '{OP_BYTE,  16'h0000, 8'h60, 1'b1, 1'b1, 16'h8003, 1'b0, 1'b0};
    // Full 64-byte palette fill from a zero length field.
    walk_table[19] = '{OP_BYTE,  16'h0000, 8'h3F, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[20] = '{OP_BYTE,  16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[21] = '{OP_BYTE,  16'h0000, 8'h40, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[22] = '{OP_BYTE,  16'h0000, 8'h5A, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    // Restart in the middle of a record, then end right away.
    walk_table[23] = '{OP_BYTE,  16'h0000, 8'h7F, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
    walk_table[24] = '{OP_START, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0};
    walk_table[25] = '{OP_BYTE,  16'h0000, 8'h80, 1'b1, 1'b0, 16'h0001, 1'b1, 1'b0};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < TABLE_ROWS; r++) begin
      typed_res = '0;
      typed_res.fetch_req = walk_table[r].fetch_req;
      typed_res.fetch_addr = walk_table[r].fetch_addr;
      typed_res.done = walk_table[r].done;
      typed_res.err = walk_table[r].err;
      typed_res.last = 1'b1;
      drive_item(walk_table[r].op, walk_table[r].addr, walk_table[r].data,
                 walk_table[r].typed, typed_res);
    end
    wait_for_drain();

    base = stim_count;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 75; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 75; end
        default: begin send_gap_pct = 20; stall_pct = 20; end
      endcase
      while (stim_count < base + (ph + 1) * RANDOM_ITEMS / 4) begin
        op = OP_BYTE;
        addr = 16'($urandom);
        b = 8'($urandom);
        pick = $urandom_range(99);
        if (parse_state == PH_IDLE) begin
          // Mostly start a new string; the rest are stray bytes that are ignored.
          if (pick < 85) begin
            op = OP_START;
            nest_mode = first_program || ($urandom_range(4) == 0);
            first_program = 1'b0;
          end
        end else if (pick < 3) begin
          op = OP_START;
          nest_mode = 1'b0;
        end else begin
          case (parse_state)
            PH_OPCODE: begin
              pick = $urandom_range(99);
              // Nesting strings jump until the return stack overflows.
              if (nest_mode && pick < 80) b = CMD_JUMP;
              else if (pick < 8) b[7] = 1'b1;
              else if (pick < 24) b = CMD_JUMP;
              else if (pick < 40 && (ret_depth != 0 || pick < 27)) b = CMD_RETURN;
              else begin
                b[7] = 1'b0;
                if (b == CMD_JUMP || b == CMD_RETURN) b[0] = ~b[0];
              end
            end
            PH_FLAGS: if ($urandom_range(3) != 0) b[5:0] = 6'($urandom_range(8, 1));
            default: ;
          endcase
        end
        drive_item(op, addr, b, 1'b0, '0);
      end
      wait_for_drain();
    end

    send_gap_pct = 0;
    stall_pct = 0;
    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results expected, 0 arrived", $time, awaited_results.size());
    end

    $display("Drove %0d command transactions through four handshake phases; %0d results checked.",
             stim_count, results_checked);
    $display("They held %0d video writes, %0d parse stops and %0d return stack errors.",
             writes_seen, stops_seen, stack_errors_seen);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
